@@ rtl/nbp_pkg.sv @@
package nbp_pkg;

  localparam int BLOCK_COUNT = 256;
  localparam int STACK_DEPTH = 64;

  localparam int BLK_AW  = $clog2(BLOCK_COUNT);
  localparam int STK_AW  = $clog2(STACK_DEPTH);
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int MARK_W  = $clog2(BLOCK_COUNT + 1);

  typedef enum logic [1:0] {
    OP_ENTER = 2'd0,
    OP_LEAVE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BAD_ID = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LV_FRAME,
    S_LV_BLOCK,
    S_LV_PARENT,
    S_ERR
  } state_t;

  // one block table entry
  typedef struct packed {
    logic [63:0] total;
    logic [63:0] root;
    logic [63:0] child;
    logic [31:0] calls;
    logic [31:0] bytes;
  } blk_rec_t;

  // one stack frame
  typedef struct packed {
    logic [7:0]  id;
    logic [63:0] start;
    logic [63:0] saved_root;
  } frame_t;

endpackage

@@ rtl/nbp_ram.sv @@
module nbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/nbp_blk_table.sv @@
module nbp_blk_table
  import nbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [BLK_AW-1:0] rd_addr,
  output blk_rec_t          rd_rec,
  input  logic              wr_en,
  input  logic [BLK_AW-1:0] wr_addr,
  input  blk_rec_t          wr_rec
);

  logic [BLOCK_COUNT-1:0] valid;
  logic                   rd_valid;
  blk_rec_t               ram_q;

  nbp_ram #(
    .WIDTH ($bits(blk_rec_t)),
    .DEPTH (BLOCK_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_rec),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_rec = rd_valid ? ram_q : '0;

endmodule

@@ rtl/nested_block_profiler_unit.sv @@
// nested block profiler
// input beat: op, block_id, timestamp, byte_count on in_valid / in_stall
// result beat: status and the addressed block's counters on out_valid /
// out_stall, exactly one result beat per input beat, in order
// enter and read: table read, then update and result;
// leave: top frame read, then block read plus parent frame read, then
// block write plus parent read, then parent write plus result
// errors (bad id, full stack, empty stack, unused op) are found on accept, then give the result
// the sequencer holds one beat at a time; in_stall is high outside idle
// the result sits in an output register; while the receiver stalls a
// finished beat, the sequencer waits in its final state with the writes of
// that state not yet done, so nothing is lost or applied twice
// reset clears the stack depth, the id high mark and the table valid bits,
// so the block table reads as zero at once; no clearing pass is needed
module nested_block_profiler_unit
  import nbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  block_id,
  input  logic [63:0] timestamp,
  input  logic [31:0] byte_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] total_ticks,
  output logic [63:0] root_ticks,
  output logic [63:0] child_ticks,
  output logic [31:0] call_count,
  output logic [31:0] block_bytes,
  output logic [8:0]  used_blocks,
  output logic [6:0]  stack_depth
);

  // control state
  state_t              state, state_next;
  logic [DEPTH_W-1:0]  depth, depth_next;
  logic [MARK_W-1:0]   mark, mark_next;
  logic                out_vld_next;

  // beat and working registers
  op_t                 op_q, op_next;
  logic [7:0]          id_q, id_next;
  logic [63:0]         ts_q, ts_next;
  logic [31:0]         bytes_q, bytes_next;
  stat_t               err_q, err_next;
  frame_t              frame_q, frame_next;
  logic [63:0]         elapsed, elapsed_next;
  blk_rec_t            bid_rec, bid_rec_next;
  logic [BLK_AW-1:0]   pid, pid_next;
  logic                has_par, has_par_next;
  logic                same, same_next;

  // result
  logic                res_load;
  stat_t               res_stat;
  blk_rec_t            res_rec;

  // memory ports
  logic                tbl_rd_en, tbl_wr_en;
  logic [BLK_AW-1:0]   tbl_rd_addr, tbl_wr_addr;
  blk_rec_t            tbl_rd_rec, tbl_wr_rec;
  logic                stk_rd_en, stk_wr_en;
  logic [STK_AW-1:0]   stk_rd_addr, stk_wr_addr;
  frame_t              stk_wr_data, stk_rd_data;

  logic                accept, can_fire, id_ok;
  blk_rec_t            upd;

  nbp_blk_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_rec  (tbl_rd_rec),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_rec  (tbl_wr_rec)
  );

  nbp_ram #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // the output register is free when empty or being drained this cycle
  assign can_fire = !out_valid || !out_stall;
  assign id_ok    = (block_id != 8'd0) && (32'(block_id) < BLOCK_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      mark      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      depth     <= depth_next;
      mark      <= mark_next;
      out_valid <= out_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q    <= op_next;
    id_q    <= id_next;
    ts_q    <= ts_next;
    bytes_q <= bytes_next;
    err_q   <= err_next;
    frame_q <= frame_next;
    elapsed <= elapsed_next;
    bid_rec <= bid_rec_next;
    pid     <= pid_next;
    has_par <= has_par_next;
    same    <= same_next;
    if (res_load) begin
      status      <= res_stat;
      total_ticks <= res_rec.total;
      root_ticks  <= res_rec.root;
      child_ticks <= res_rec.child;
      call_count  <= res_rec.calls;
      block_bytes <= res_rec.bytes;
      used_blocks <= 9'(mark_next);
      stack_depth <= 7'(depth_next);
    end
  end

  always_comb begin
    state_next   = state;
    depth_next   = depth;
    mark_next    = mark;
    op_next      = op_q;
    id_next      = id_q;
    ts_next      = ts_q;
    bytes_next   = bytes_q;
    err_next     = err_q;
    frame_next   = frame_q;
    elapsed_next = elapsed;
    bid_rec_next = bid_rec;
    pid_next     = pid;
    has_par_next = has_par;
    same_next    = same;

    res_load = 1'b0;
    res_stat = STAT_OK;
    res_rec  = '0;
    upd      = tbl_rd_rec;

    tbl_rd_en   = 1'b0;
    tbl_rd_addr = BLK_AW'(block_id);
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = BLK_AW'(id_q);
    tbl_wr_rec  = tbl_rd_rec;
    stk_rd_en   = 1'b0;
    stk_rd_addr = STK_AW'(depth - DEPTH_W'(1));
    stk_wr_en   = 1'b0;
    stk_wr_addr = STK_AW'(depth);
    stk_wr_data = '{id: id_q, start: ts_q, saved_root: tbl_rd_rec.root};

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_next    = op_t'(op);
          id_next    = block_id;
          ts_next    = timestamp;
          bytes_next = byte_count;
          case (op_t'(op))
            OP_ENTER: begin
              if (!id_ok) begin
                err_next   = STAT_BAD_ID;
                state_next = S_ERR;
              end else if (depth >= DEPTH_W'(STACK_DEPTH)) begin
                err_next   = STAT_FULL;
                state_next = S_ERR;
              end else begin
                tbl_rd_en  = 1'b1;
                state_next = S_FETCH;
              end
            end
            OP_LEAVE: begin
              if (depth == '0) begin
                err_next   = STAT_EMPTY;
                state_next = S_ERR;
              end else begin
                // top frame
                stk_rd_en  = 1'b1;
                state_next = S_LV_FRAME;
              end
            end
            OP_READ: begin
              if (!id_ok) begin
                err_next   = STAT_BAD_ID;
                state_next = S_ERR;
              end else begin
                tbl_rd_en  = 1'b1;
                state_next = S_FETCH;
              end
            end
            default: begin
              err_next   = STAT_BAD_ID;
              state_next = S_ERR;
            end
          endcase
        end
      end

      S_FETCH: begin
        if (op_q == OP_ENTER) begin
          upd.calls = tbl_rd_rec.calls + 32'd1;
          upd.bytes = bytes_q;
        end
        if (can_fire) begin
          res_load = 1'b1;
          res_rec  = upd;
          if (op_q == OP_ENTER) begin
            tbl_wr_en  = 1'b1;
            tbl_wr_rec = upd;
            // push with the root time held before this activation
            stk_wr_en  = 1'b1;
            depth_next = depth + DEPTH_W'(1);
            if (mark <= MARK_W'(id_q)) begin
              mark_next = MARK_W'(id_q) + MARK_W'(1);
            end
          end
          state_next = S_IDLE;
        end
      end

      S_LV_FRAME: begin
        frame_next   = stk_rd_data;
        elapsed_next = ts_q - stk_rd_data.start;
        has_par_next = (depth > DEPTH_W'(1));
        tbl_rd_en    = 1'b1;
        tbl_rd_addr  = BLK_AW'(stk_rd_data.id);
        // parent frame, only its id is used
        stk_rd_en    = (depth > DEPTH_W'(1));
        stk_rd_addr  = STK_AW'(depth - DEPTH_W'(2));
        state_next   = S_LV_BLOCK;
      end

      S_LV_BLOCK: begin
        upd.total    = tbl_rd_rec.total + elapsed;
        upd.root     = frame_q.saved_root + elapsed;
        bid_rec_next = upd;
        tbl_wr_en    = 1'b1;
        tbl_wr_addr  = BLK_AW'(frame_q.id);
        tbl_wr_rec   = upd;
        pid_next     = BLK_AW'(stk_rd_data.id);
        same_next    = (stk_rd_data.id == frame_q.id);
        // a read of the entry written this cycle returns stale data,
        // the same flag forwards the fresh record instead
        tbl_rd_en    = has_par;
        tbl_rd_addr  = BLK_AW'(stk_rd_data.id);
        state_next   = S_LV_PARENT;
      end

      S_LV_PARENT: begin
        upd       = same ? bid_rec : tbl_rd_rec;
        upd.child = upd.child + elapsed;
        if (can_fire) begin
          res_load    = 1'b1;
          res_rec     = (has_par && same) ? upd : bid_rec;
          tbl_wr_en   = has_par;
          tbl_wr_addr = pid;
          tbl_wr_rec  = upd;
          depth_next  = depth - DEPTH_W'(1);
          state_next  = S_IDLE;
        end
      end

      S_ERR: begin
        if (can_fire) begin
          res_load   = 1'b1;
          res_stat   = err_q;
          res_rec    = '0;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (res_load) begin
      out_vld_next = 1'b1;
    end else if (!out_stall) begin
      out_vld_next = 1'b0;
    end else begin
      out_vld_next = out_valid;
    end
  end

endmodule

@@ bench/nbp_score_pkg.sv @@
package nbp_score_pkg;
  import nbp_pkg::*;

  // one result beat as seen on the output ports
  typedef struct packed {
    stat_t       status;
    logic [63:0] total;
    logic [63:0] root;
    logic [63:0] child;
    logic [31:0] calls;
    logic [31:0] last_bytes;
    logic [8:0]  used;
    logic [6:0]  depth;
  } prof_result_t;

  class profile_scoreboard;
    logic [63:0] total_tab [BLOCK_COUNT];
    logic [63:0] root_tab  [BLOCK_COUNT];
    logic [63:0] child_tab [BLOCK_COUNT];
    logic [31:0] calls_tab [BLOCK_COUNT];
    logic [31:0] bytes_tab [BLOCK_COUNT];
    logic [7:0]  frame_id    [STACK_DEPTH];
    logic [63:0] frame_start [STACK_DEPTH];
    logic [63:0] frame_root  [STACK_DEPTH];
    int unsigned depth;
    int unsigned high_mark;
    prof_result_t expected_q [$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      foreach (total_tab[i]) begin
        total_tab[i] = '0;
        root_tab[i]  = '0;
        child_tab[i] = '0;
        calls_tab[i] = '0;
        bytes_tab[i] = '0;
      end
      depth        = 0;
      high_mark    = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int unsigned open_frames();
      return depth;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // work out the result of one accepted input beat and queue it
    function void note_beat(op_t cmd, logic [7:0] blk, logic [63:0] stamp,
                            logic [31:0] nbytes);
      prof_result_t r;
      logic [63:0]  elapsed;
      logic [7:0]   shown;
      int unsigned  top;
      bit           have;
      r = '0;
      r.status = STAT_OK;
      have = 1'b0;
      shown = '0;
      case (cmd)
        OP_ENTER: begin
          if (blk == 0 || blk >= BLOCK_COUNT) begin
            r.status = STAT_BAD_ID;
          end else if (depth >= STACK_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            bytes_tab[blk] = nbytes;
            if (high_mark <= blk) high_mark = blk + 1;
            calls_tab[blk] = calls_tab[blk] + 32'd1;
            frame_id[depth]    = blk;
            frame_start[depth] = stamp;
            frame_root[depth]  = root_tab[blk];
            depth++;
            have = 1'b1;
            shown = blk;
          end
        end
        OP_LEAVE: begin
          if (depth == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            top = depth - 1;
            shown = frame_id[top];
            elapsed = stamp - frame_start[top];
            total_tab[shown] = total_tab[shown] + elapsed;
            root_tab[shown]  = frame_root[top] + elapsed;
            depth = top;
            if (depth > 0)
              child_tab[frame_id[depth-1]] = child_tab[frame_id[depth-1]] + elapsed;
            have = 1'b1;
          end
        end
        OP_READ: begin
          if (blk == 0 || blk >= BLOCK_COUNT) begin
            r.status = STAT_BAD_ID;
          end else begin
            have = 1'b1;
            shown = blk;
          end
        end
        default: r.status = STAT_BAD_ID;
      endcase
      if (have) begin
        r.total      = total_tab[shown];
        r.root       = root_tab[shown];
        r.child      = child_tab[shown];
        r.calls      = calls_tab[shown];
        r.last_bytes = bytes_tab[shown];
      end
      r.used  = high_mark[8:0];
      r.depth = depth[6:0];
      expected_q.push_back(r);
    endfunction

    function void flag(string what, prof_result_t want, prof_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s at result %0d", what, results_seen);
        $display("  status exp %0d got %0d, used exp %0d got %0d, depth exp %0d got %0d",
                 want.status, got.status, want.used, got.used, want.depth, got.depth);
        $display("  total exp %h got %h, root exp %h got %h",
                 want.total, got.total, want.root, got.root);
        $display("  child exp %h got %h, calls exp %h got %h, bytes exp %h got %h",
                 want.child, got.child, want.calls, got.calls,
                 want.last_bytes, got.last_bytes);
      end
    endfunction

    // compare one accepted result beat with the oldest expectation
    function void check_beat(prof_result_t got);
      prof_result_t want;
      if (expected_q.size() == 0) begin
        flag("result with nothing outstanding", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.total !== want.total ||
          got.root !== want.root || got.child !== want.child ||
          got.calls !== want.calls || got.last_bytes !== want.last_bytes ||
          got.used !== want.used || got.depth !== want.depth)
        flag("mismatch", want, got);
      results_seen++;
    endfunction
  endclass

endpackage

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nbp_pkg::*;
  import nbp_score_pkg::*;

  // generous bound: every beat at its slowest with the longest gaps and stalls
  localparam int unsigned CYCLE_LIMIT = 800_000;
  localparam int ITEM_TARGET  = 1750;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 12;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  op;
  logic [7:0]  block_id;
  logic [63:0] timestamp;
  logic [31:0] byte_count;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [63:0] total_ticks;
  logic [63:0] root_ticks;
  logic [63:0] child_ticks;
  logic [31:0] call_count;
  logic [31:0] block_bytes;
  logic [8:0]  used_blocks;
  logic [6:0]  stack_depth;

  profile_scoreboard sb = new();

  int unsigned cycles = 0;
  int          sent   = 0;
  logic [63:0] tick   = '0;   // event time, moved on by next_stamp for each generated beat
  int          tx_mode = 0;   // sender idling: 0 none, 1 light, 2 heavy
  int          rx_mode = 0;   // receiver stalling, same scale
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;

  nested_block_profiler_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .block_id    (block_id),
    .timestamp   (timestamp),
    .byte_count  (byte_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .total_ticks (total_ticks),
    .root_ticks  (root_ticks),
    .child_ticks (child_ticks),
    .call_count  (call_count),
    .block_bytes (block_bytes),
    .used_blocks (used_blocks),
    .stack_depth (stack_depth)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("nested_block_profiler_unit verification failed");
      $finish;
    end
  end

  // stall length: nine draws in ten from the short range, the rest from the long one
  function automatic int pick_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_gap(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 1) return (r < 75) ? 0 : pick_len();
    return (r < 40) ? 0 : pick_len();
  endfunction

  // ids: a small hot set so that blocks recurse and counters pile up,
  // plus the full range, the top id and the invalid id 0
  function automatic logic [7:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 8'($urandom_range(1, 6));
    if (r < 85) return 8'($urandom_range(1, 255));
    if (r < 90) return 8'd255;
    if (r < 95) return 8'd128;
    return 8'd0;
  endfunction

  function automatic logic [7:0] pick_good_id();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(1, 6));
    return 8'($urandom_range(1, 255));
  endfunction

  // mostly small forward steps, sometimes big ones, sometimes a jump
  // anywhere so that elapsed times wrap
  function automatic logic [63:0] next_stamp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80)      tick = tick + 64'($urandom_range(0, 1000));
    else if (r < 95) tick = tick + 64'($urandom);
    else             tick = {$urandom, $urandom};
    return tick;
  endfunction

  // offer one input beat after a random gap and hold it until accepted
  task automatic send_beat(op_t cmd, logic [7:0] blk, logic [63:0] stamp,
                           logic [31:0] nbytes);
    int gap;
    gap = pick_gap(tx_mode);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    op         <= cmd;
    block_id   <= blk;
    timestamp  <= stamp;
    byte_count <= nbytes;
    do @(posedge clk); while (in_stall);
    sb.note_beat(cmd, blk, stamp, nbytes);
    sent++;
  endtask

  // push to the stack limit, knock on the full stack, then unwind past empty
  task automatic fill_stack();
    while (sb.open_frames() < STACK_DEPTH)
      send_beat(OP_ENTER, pick_good_id(), next_stamp(), $urandom);
    // bad id wins over full stack
    send_beat(OP_ENTER, 8'd0, next_stamp(), $urandom);
    send_beat(OP_ENTER, pick_good_id(), next_stamp(), $urandom);
    send_beat(OP_READ, pick_good_id(), next_stamp(), $urandom);
    while (sb.open_frames() > 0)
      send_beat(OP_LEAVE, 8'($urandom), next_stamp(), $urandom);
    send_beat(OP_LEAVE, 8'($urandom), next_stamp(), $urandom);
  endtask

  // well-formed nesting with random content, capped at a per-session depth
  task automatic run_session(int n);
    int max_d;
    int d;
    int r;
    op_t cmd;
    max_d = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      d = sb.open_frames();
      r = $urandom_range(0, 99);
      if (r < 3)           cmd = OP_NONE;
      else if (d == 0)     cmd = (r < 90) ? OP_ENTER : OP_READ;
      else if (d >= max_d) cmd = (r < 75) ? OP_LEAVE : OP_READ;
      else if (r < 50)     cmd = OP_ENTER;
      else if (r < 85)     cmd = OP_LEAVE;
      else                 cmd = OP_READ;
      send_beat(cmd, pick_id(), next_stamp(), $urandom);
    end
  endtask

  // fully random fields, including unused op and stray timestamps
  task automatic run_noise(int n);
    for (int i = 0; i < n; i++)
      send_beat(op_t'($urandom_range(0, 3)), 8'($urandom), {$urandom, $urandom}, $urandom);
  endtask

  task automatic run_directed();
    // fresh table reads as zero, then the bad id, empty stack and unused op errors
    send_beat(OP_READ,  8'd1,   64'd0, 32'd0);
    send_beat(OP_READ,  8'd0,   64'd0, 32'd0);
    send_beat(OP_LEAVE, 8'd7,   64'd3, 32'd0);
    send_beat(OP_NONE,  8'd1,   64'd0, 32'd0);
    send_beat(OP_ENTER, 8'd0,   64'd1, 32'hFFFF_FFFF);
    // top id pushes the high mark to its limit
    send_beat(OP_ENTER, 8'd255, 64'd0, 32'hFFFF_FFFF);
    send_beat(OP_ENTER, 8'd1,   64'd5, 32'd0);
    // block re-entered inside itself
    send_beat(OP_ENTER, 8'd1,   64'd10, 32'h8000_0001);
    send_beat(OP_LEAVE, 8'd0,   64'd30, 32'd0);
    send_beat(OP_LEAVE, 8'd0,   64'd40, 32'd0);
    send_beat(OP_READ,  8'd1,   64'd0, 32'd0);
    // elapsed time across the 64-bit wrap
    send_beat(OP_ENTER, 8'd128, 64'hFFFF_FFFF_FFFF_FFF0, 32'h5555_5555);
    send_beat(OP_LEAVE, 8'hFF,  64'h10, 32'hAAAA_AAAA);
    send_beat(OP_LEAVE, 8'd0,   64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_beat(OP_LEAVE, 8'd0,   64'd0, 32'd0);
    send_beat(OP_ENTER, 8'd2,   64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
    send_beat(OP_LEAVE, 8'd0,   64'd0, 32'd0);
    send_beat(OP_READ,  8'd255, 64'd0, 32'd0);
    send_beat(OP_READ,  8'd128, 64'd0, 32'd0);
    send_beat(OP_READ,  8'd2,   64'd0, 32'd0);
    send_beat(OP_NONE,  8'hFF,  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // receiver: random stalls of mixed length, and one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (rx_mode != 0 && $urandom_range(0, 99) < ((rx_mode == 1) ? 15 : 40))
          stall_left = pick_len();
      end
    end
  end

  // every accepted result beat goes to the scoreboard
  always @(posedge clk) begin : result_monitor
    prof_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.status     = stat_t'(status);
      got.total      = total_ticks;
      got.root       = root_ticks;
      got.child      = child_ticks;
      got.calls      = call_count;
      got.last_bytes = block_bytes;
      got.used       = used_blocks;
      got.depth      = stack_depth;
      sb.check_beat(got);
    end
  end

  initial begin
    int r;
    rst        = 1'b1;
    in_valid   = 1'b0;
    op         = OP_ENTER;
    block_id   = '0;
    timestamp  = '0;
    byte_count = '0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    tx_mode = 0;
    rx_mode = 1;
    run_directed();

    // first random phase reaches the full stack straight away
    tx_mode = 1;
    rx_mode = 0;
    fill_stack();

    while (sent < ITEM_TARGET) begin
      tx_mode = $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      // halfway through, the receiver holds off while the sender keeps offering beats
      if (!hold_done && sent > ITEM_TARGET / 2) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 75)      run_session($urandom_range(10, 60));
      else if (r < 88) run_noise($urandom_range(5, 20));
      else if (r < 93) fill_stack();
      else begin
        // unwind whatever is open and knock on the empty stack
        while (sb.open_frames() > 0)
          send_beat(OP_LEAVE, 8'($urandom), next_stamp(), $urandom);
        send_beat(OP_LEAVE, 8'($urandom), next_stamp(), $urandom);
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    rx_mode = 0;
    while (sb.pending() != 0) @(posedge clk);
    // catch any stray beat after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("nested_block_profiler_unit verification clean");
    else
      $display("nested_block_profiler_unit verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/nbp_pkg.sv
rtl/nbp_ram.sv
rtl/nbp_blk_table.sv
rtl/nested_block_profiler_unit.sv
bench/nbp_score_pkg.sv
bench/tb_top.sv
